FILE: sv/stws_pkg.sv
// Shared types, codes and reset constants for the spin-then-wait semaphore.
// No dependencies; every other file of the block imports this package.
package stws_pkg;

  // Fixed field widths of the request and result words
  localparam int unsigned REQ_TYPE_W     = 2;
  localparam int unsigned REL_COUNT_W    = 15;
  localparam int unsigned SPIN_ROUND_W   = 4;
  localparam int unsigned OUTCOME_W      = 3;
  localparam int unsigned SLEEP_MS_W     = 5;
  localparam int unsigned WOKEN_W        = 15;
  localparam int unsigned NUM_PROC_W     = 11;
  localparam int unsigned MAX_COUNT_W    = 15;

  // Stream word widths (fields packed, padded to whole bytes)
  localparam int unsigned S_TDATA_W      = 24;
  localparam int unsigned S_TUSER_W      = REQ_TYPE_W;
  localparam int unsigned M_TDATA_W      = 24;
  localparam int unsigned M_TUSER_W      = OUTCOME_W;

  // Configuration port
  localparam int unsigned APB_ADDR_W     = 3;
  localparam int unsigned APB_DATA_W     = 32;

  // Default counter width and register reset values
  localparam int unsigned DEFAULT_COUNT_WIDTH = 15;
  localparam logic [NUM_PROC_W-1:0]  NUM_PROC_RESET  = 11'd8;
  localparam logic [MAX_COUNT_W-1:0] MAX_COUNT_RESET = 15'h7fff;

  // Register indexes (byte address / 4)
  typedef enum logic {
    REG_NUM_PROCESSORS = 1'b0,
    REG_MAX_COUNT      = 1'b1
  } reg_idx_e;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_RELEASE     = 2'd0,
    REQ_WAIT_ENTER  = 2'd1,
    REQ_SPINNER_POLL = 2'd2,
    REQ_WAITER_POLL = 2'd3
  } req_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_DONE          = 3'd0,
    OUT_ACQUIRED      = 3'd1,
    OUT_NOW_SPINNER   = 3'd2,
    OUT_NOW_WAITER    = 3'd3,
    OUT_SLEEP         = 3'd4,
    OUT_TIMED_OUT     = 3'd5,
    OUT_STILL_WAITING = 3'd6
  } outcome_e;

  // Spinner rounds at or above this demote; backoff caps at this shift
  localparam logic [SPIN_ROUND_W-1:0] DEMOTE_ROUND = 4'd8;
  localparam logic [SPIN_ROUND_W-1:0] MAX_SHIFT    = 4'd4;

  typedef struct packed {
    req_e                    req_type;
    logic [REL_COUNT_W-1:0]  release_count;
    logic [SPIN_ROUND_W-1:0] spin_round;
    logic                    timed_out;
  } req_t;

  typedef struct packed {
    outcome_e               outcome;
    logic [SLEEP_MS_W-1:0]  sleep_ms;
    logic [WOKEN_W-1:0]     waiters_woken;
    logic                   overflow;
  } res_t;

  typedef struct packed {
    logic [NUM_PROC_W-1:0]  num_processors;
    logic [MAX_COUNT_W-1:0] max_count;
  } cfg_t;

endpackage

FILE: sv/stws_apb_regs.sv
// APB configuration registers: processor count and granted-count limit.
// Depends on stws_pkg.
module stws_apb_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [stws_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [stws_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [stws_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output stws_pkg::cfg_t                    cfg_o
);
  import stws_pkg::*;

  logic [NUM_PROC_W-1:0]  num_proc_q;
  logic [MAX_COUNT_W-1:0] max_count_q;
  reg_idx_e               idx;
  logic                   wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_proc_q  <= NUM_PROC_RESET;
      max_count_q <= MAX_COUNT_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_NUM_PROCESSORS: num_proc_q  <= pwdata[NUM_PROC_W-1:0];
        REG_MAX_COUNT:      max_count_q <= pwdata[MAX_COUNT_W-1:0];
        default:            ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    prdata = '0;
    case (idx)
      REG_NUM_PROCESSORS: prdata = APB_DATA_W'(num_proc_q);
      REG_MAX_COUNT:      prdata = APB_DATA_W'(max_count_q);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o.num_processors = num_proc_q;
  assign cfg_o.max_count      = max_count_q;

endmodule

FILE: sv/stws_core.sv
// Semaphore counters and the per-request update logic; one request per fire.
// Depends on stws_pkg.
module stws_core #(
  parameter int unsigned COUNT_WIDTH = stws_pkg::DEFAULT_COUNT_WIDTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  stws_pkg::req_t req_i,
  input  stws_pkg::cfg_t cfg_i,
  output stws_pkg::res_t res_o
);
  import stws_pkg::*;

  // Working width for release arithmetic: covers counters and 15-bit counts
  localparam int unsigned WW =
    ((COUNT_WIDTH > REL_COUNT_W) ? COUNT_WIDTH : REL_COUNT_W) + 1;
  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};
  localparam logic [WW-1:0]          CMAX_W = WW'(CMAX);

  logic [COUNT_WIDTH-1:0] spin_cnt_q, spin_cnt_d;
  logic [COUNT_WIDTH-1:0] wait_cnt_q, wait_cnt_d;
  logic [COUNT_WIDTH-1:0] spin_grant_q, spin_grant_d;
  logic [COUNT_WIDTH-1:0] wait_grant_q, wait_grant_d;
  logic [COUNT_WIDTH-1:0] tokens_q, tokens_d;

  logic [WW-1:0] limit, granted, room, rc_eff, sp_need, wt_need;
  logic [WW-1:0] to_sp, rem, to_wt, sg_sum, tok_sum;
  logic [WW-1:0] half_np;
  logic          clip;

  // Saturating counter helpers
  function automatic logic [COUNT_WIDTH-1:0] inc_sat(input logic [COUNT_WIDTH-1:0] v);
    return (v == CMAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] dec_sat(input logic [COUNT_WIDTH-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  // Release split: clip to room, then spinners lacking count, then waiters; any excess stays with spinners
  always_comb begin
    limit   = (WW'(cfg_i.max_count) < CMAX_W) ? WW'(cfg_i.max_count) : CMAX_W;
    granted = WW'(spin_grant_q) + WW'(wait_grant_q);
    room    = (limit > granted) ? limit - granted : '0;
    clip    = WW'(req_i.release_count) > room;
    rc_eff  = clip ? room : WW'(req_i.release_count);
    sp_need = (spin_cnt_q > spin_grant_q) ? WW'(spin_cnt_q - spin_grant_q) : '0;
    wt_need = (wait_cnt_q > wait_grant_q) ? WW'(wait_cnt_q - wait_grant_q) : '0;
    to_sp   = (rc_eff < sp_need) ? rc_eff : sp_need;
    rem     = rc_eff - to_sp;
    to_wt   = (rem < wt_need) ? rem : wt_need;
    sg_sum  = WW'(spin_grant_q) + rc_eff - to_wt;
    tok_sum = WW'(tokens_q) + to_wt;
    half_np = WW'(cfg_i.num_processors >> 1);
  end

  // Next state and result for the request in hand
  always_comb begin
    spin_cnt_d   = spin_cnt_q;
    wait_cnt_d   = wait_cnt_q;
    spin_grant_d = spin_grant_q;
    wait_grant_d = wait_grant_q;
    tokens_d     = tokens_q;
    res_o        = '0;
    res_o.outcome = OUT_DONE;
    case (req_i.req_type)
      REQ_RELEASE: begin
        spin_grant_d = sg_sum[COUNT_WIDTH-1:0];
        wait_grant_d = wait_grant_q + to_wt[COUNT_WIDTH-1:0];
        tokens_d     = (tok_sum > CMAX_W) ? CMAX : tok_sum[COUNT_WIDTH-1:0];
        res_o.waiters_woken = to_wt[WOKEN_W-1:0];
        res_o.overflow      = clip;
        res_o.outcome       = OUT_DONE;
      end
      REQ_WAIT_ENTER: begin
        if (spin_grant_q != '0) begin
          spin_grant_d  = spin_grant_q - 1'b1;
          res_o.outcome = OUT_ACQUIRED;
        end else begin
          spin_cnt_d    = inc_sat(spin_cnt_q);
          res_o.outcome = OUT_NOW_SPINNER;
        end
      end
      REQ_SPINNER_POLL: begin
        if (spin_grant_q != '0) begin
          spin_grant_d  = spin_grant_q - 1'b1;
          spin_cnt_d    = dec_sat(spin_cnt_q);
          res_o.outcome = OUT_ACQUIRED;
        end else if (req_i.spin_round >= DEMOTE_ROUND || WW'(spin_cnt_q) >= half_np) begin
          spin_cnt_d    = dec_sat(spin_cnt_q);
          wait_cnt_d    = inc_sat(wait_cnt_q);
          res_o.outcome = OUT_NOW_WAITER;
        end else begin
          // Exponential backoff, capped at 16 ms
          res_o.sleep_ms = (req_i.spin_round >= MAX_SHIFT) ? 5'd16
                         : 5'd1 << req_i.spin_round[1:0];
          res_o.outcome  = OUT_SLEEP;
        end
      end
      REQ_WAITER_POLL: begin
        if (tokens_q != '0) begin
          tokens_d      = tokens_q - 1'b1;
          wait_cnt_d    = dec_sat(wait_cnt_q);
          wait_grant_d  = dec_sat(wait_grant_q);
          res_o.outcome = OUT_ACQUIRED;
        end else if (req_i.timed_out) begin
          wait_cnt_d    = dec_sat(wait_cnt_q);
          res_o.outcome = OUT_TIMED_OUT;
        end else begin
          res_o.outcome = OUT_STILL_WAITING;
        end
      end
      default: res_o.outcome = OUT_DONE;
    endcase
  end

  // Counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_cnt_q   <= '0;
      wait_cnt_q   <= '0;
      spin_grant_q <= '0;
      wait_grant_q <= '0;
      tokens_q     <= '0;
    end else if (fire_i) begin
      spin_cnt_q   <= spin_cnt_d;
      wait_cnt_q   <= wait_cnt_d;
      spin_grant_q <= spin_grant_d;
      wait_grant_q <= wait_grant_d;
      tokens_q     <= tokens_d;
    end
  end

endmodule

FILE: sv/spin_then_wait_semaphore.sv
// Top level of the spin-then-wait semaphore: request register, core, result register.
// Depends on stws_pkg, stws_apb_regs and stws_core.
//
//   channel   direction  handshake                     contents
//   s_axis    in         tvalid/tready                 request word
//   m_axis    out        tvalid/tready                 result word
//   apb       in/out     psel/penable/pwrite, pready   num_processors, max_count
//
// One request per cycle while m_axis takes results; a result word is offered
// on m_axis once its request has passed the request register and then the
// result register. The counter update is one pass of logic in the core, so
// back-to-back requests chain through it.
// Reset clears the counters and valid flags; registers return to 8 / 32767.
// A stalled m_axis holds the result; s_axis takes one more request only into an empty request register.
module spin_then_wait_semaphore #(
  parameter int unsigned COUNT_WIDTH = stws_pkg::DEFAULT_COUNT_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [14:0] release_count, [18:15] spin_round, [19] timed_out, [23:20] zero
  input  logic [stws_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] req_type
  input  logic [stws_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [4:0] sleep_ms, [19:5] waiters_woken, [20] overflow, [23:21] zero
  output logic [stws_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [2:0] outcome
  output logic [stws_pkg::M_TUSER_W-1:0]   m_axis_tuser,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [stws_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [stws_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [stws_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import stws_pkg::*;

  cfg_t cfg;
  req_t in_req_q, in_req_d;
  res_t out_res_q, core_res;
  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic s_accept, out_free, advance;

  stws_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: the request register moves on whenever the result slot frees
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Unpack the incoming word
  always_comb begin
    in_req_d.req_type      = req_e'(s_axis_tuser);
    in_req_d.release_count = s_axis_tdata[14:0];
    in_req_d.spin_round    = s_axis_tdata[18:15];
    in_req_d.timed_out     = s_axis_tdata[19];
    in_valid_d  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  stws_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .req_i  (in_req_q),
    .cfg_i  (cfg),
    .res_o  (core_res)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_req_q <= in_req_d;
    end
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  // Pack the result word
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.outcome;
  assign m_axis_tdata  = {3'b000, out_res_q.overflow, out_res_q.waiters_woken,
                          out_res_q.sleep_ms};

endmodule
